// File: hdl/llc_pkg.sv
// Shared types, sizes and command codes of the LED layer compositor.
package llc_pkg;

  // Store geometry.
  localparam int LAYERS      = 4;
  localparam int LED_COUNT   = 32;
  localparam int LAYER_W     = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int LED_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int ADDR_W      = LAYER_W + LED_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // Command queue between the front and back ends; depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Channel maximum for the saturating sum.
  localparam logic [7:0] CHAN_MAX = 8'd255;

  // Command codes as they arrive on the input channel.
  localparam logic [2:0] CMD_SET       = 3'd0;
  localparam logic [2:0] CMD_FILL      = 3'd1;
  localparam logic [2:0] CMD_CLEAR     = 3'd2;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd3;
  localparam logic [2:0] CMD_COMPOSE   = 3'd4;

  // Operations that survive classification.
  typedef enum logic [2:0] {
    OP_SET,
    OP_FILL,
    OP_CLEAR,
    OP_CLEAR_ALL,
    OP_COMPOSE
  } llc_op_e;

  // One input item.
  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] layer_index;
    logic [5:0] led_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } llc_in_t;

  // One result item.
  typedef struct packed {
    logic [5:0] led_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_led;
  } llc_out_t;

  // A classified operation as it travels through the queue.
  typedef struct packed {
    llc_op_e            op;
    logic [LAYER_W-1:0] layer;
    logic [LED_W-1:0]   led;
    logic [23:0]        color;
  } llc_cmd_t;

endpackage

// File: hdl/led_layer_compositor.sv
// Top level of the LED layer compositor: front end, command queue, back end.
//
// The block keeps an RGB color per LED for each of LAYERS layers in a store with
// one write port and a registered read port. Set, clear-layer and clear-all are
// done as the back end takes them (clears work on per-entry valid bits, so reset
// and clear need no sweep); fill writes one LED per cycle. Compose reads one layer
// entry per cycle while the result output is not stalled; an item passes through
// the front end's holding register and the queue before it reaches the back end,
// and each result item goes through the read stage and the result register after
// the read of its last layer. Compose emits one result item per LED in ascending
// order with last_led on the final one; a stalled result output holds the read
// pipeline. A two-entry queue lets the front end keep taking items while the back
// end is busy; commands that do nothing are dropped at the front end.
module led_layer_compositor
  import llc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  llc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output llc_out_t out_data
);

  logic     f_valid;
  logic     f_ready;
  llc_cmd_t f_data;
  logic     q_valid;
  logic     q_ready;
  llc_cmd_t q_data;

  llc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_data   (f_data)
  );

  llc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  llc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The frame commit flag marks exactly the highest LED.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_led == (out_data.led_out == 6'(LED_COUNT - 1))))
    else $error("last_led does not match the final LED index");

  // Within a compose run the LED index steps by one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_led |=>
      !out_valid || out_data.led_out == $past(out_data.led_out) + 6'd1)
    else $error("compose results out of order");

  // A new compose run starts at LED zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_led |=>
      !out_valid || out_data.led_out == 6'd0)
    else $error("compose run does not start at LED zero");

endmodule

// File: hdl/llc_front.sv
// Front end: accepts input items, range-checks and classifies them.
module llc_front
  import llc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  llc_in_t  in_data,
  output logic     f_valid,
  input  logic     f_ready,
  output llc_cmd_t f_data
);

  logic     keep;
  llc_op_e  op;
  logic     layer_ok;
  logic     led_ok;

  // Range checks against the configured store size.
  assign layer_ok = int'(in_data.layer_index) < LAYERS;
  assign led_ok   = int'(in_data.led_index) < LED_COUNT;

  // Decide which commands do anything at all.
  always_comb begin
    op   = OP_SET;
    keep = 1'b0;
    unique case (in_data.cmd)
      CMD_SET: begin
        op   = OP_SET;
        keep = layer_ok && led_ok;
      end
      CMD_FILL: begin
        op   = OP_FILL;
        keep = layer_ok;
      end
      CMD_CLEAR: begin
        op   = OP_CLEAR;
        keep = layer_ok;
      end
      CMD_CLEAR_ALL: begin
        op   = OP_CLEAR_ALL;
        keep = 1'b1;
      end
      CMD_COMPOSE: begin
        op   = OP_COMPOSE;
        keep = 1'b1;
      end
      default: begin
        op   = OP_SET;
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = !f_valid || f_ready;

  // Holding register for one classified item.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= keep;
    end else if (f_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_data.op    <= op;
      f_data.layer <= in_data.layer_index[LAYER_W-1:0];
      f_data.led   <= in_data.led_index[LED_W-1:0];
      f_data.color <= {in_data.red_in, in_data.green_in, in_data.blue_in};
    end
  end

endmodule

// File: hdl/llc_queue.sv
// Short command queue that decouples the front end from the back end.
module llc_queue
  import llc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  llc_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output llc_cmd_t pop_data
);

  llc_cmd_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/llc_back.sv
// Back end: carries out store updates and streams composed LED colors.
module llc_back
  import llc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  output logic     q_ready,
  input  llc_cmd_t q_data,
  output logic     out_valid,
  input  logic     out_ready,
  output llc_out_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_COMPOSE
  } state_t;

  state_t             state;
  logic [LED_W-1:0]   cnt_led;
  logic [LAYER_W-1:0] cnt_layer;
  logic [LAYER_W-1:0] cur_layer;
  logic [23:0]        cur_color;

  logic [23:0]            mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [23:0]       wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              issue;
  logic              adv;
  logic              take;

  // Read stage.
  logic              rd_vld;
  logic [23:0]       rd_data;
  logic              rd_ok;
  logic [LED_W-1:0]  rd_led;
  logic              rd_first;
  logic              rd_final_layer;

  // Accumulator stage.
  logic [7:0]  acc_r;
  logic [7:0]  acc_g;
  logic [7:0]  acc_b;
  logic [23:0] term;
  logic [7:0]  sum_r;
  logic [7:0]  sum_g;
  logic [7:0]  sum_b;

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? CHAN_MAX : s[7:0];
  endfunction

  // The compose pipeline moves only when the result register can take a value.
  assign adv     = !out_valid || out_ready;
  assign q_ready = state == ST_IDLE;
  assign take    = q_valid && q_ready;
  assign issue   = (state == ST_COMPOSE) && adv;
  assign rd_addr = {cnt_layer, cnt_led};

  // Write port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {q_data.layer, q_data.led};
    wr_data = q_data.color;
    if (take && q_data.op == OP_SET) begin
      wr_en = 1'b1;
    end else if (state == ST_FILL) begin
      wr_en   = 1'b1;
      wr_addr = {cur_layer, cnt_led};
      wr_data = cur_color;
    end
  end

  // Layer store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Entry valid bits; an entry without its bit reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (take && q_data.op == OP_CLEAR) begin
        for (int i = 0; i < LED_COUNT; i++) begin
          vld[{q_data.layer, LED_W'(i)}] <= 1'b0;
        end
      end else if (take && q_data.op == OP_CLEAR_ALL) begin
        vld <= '0;
      end
    end
  end

  // Sequencer for fill and compose sweeps.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt_led   <= '0;
      cnt_layer <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          cnt_led   <= '0;
          cnt_layer <= '0;
          if (take && q_data.op == OP_FILL) begin
            state <= ST_FILL;
          end else if (take && q_data.op == OP_COMPOSE) begin
            state <= ST_COMPOSE;
          end
        end
        ST_FILL: begin
          cnt_led <= cnt_led + 1'b1;
          if (cnt_led == LED_W'(LED_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_COMPOSE: begin
          if (issue) begin
            if (cnt_layer == LAYER_W'(LAYERS - 1)) begin
              cnt_layer <= '0;
              cnt_led   <= cnt_led + 1'b1;
              if (cnt_led == LED_W'(LED_COUNT - 1)) begin
                state <= ST_IDLE;
              end
            end else begin
              cnt_layer <= cnt_layer + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Operands of a fill sweep.
  always_ff @(posedge clk) begin
    if (take) begin
      cur_layer <= q_data.layer;
      cur_color <= q_data.color;
    end
  end

  // Read stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (adv) begin
      rd_vld <= issue;
    end
  end

  // Read stage tags travel with the memory data.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ok          <= vld[rd_addr];
      rd_led         <= cnt_led;
      rd_first       <= cnt_layer == '0;
      rd_final_layer <= cnt_layer == LAYER_W'(LAYERS - 1);
    end
  end

  // Saturating sum of the current layer onto the running total.
  assign term  = rd_ok ? rd_data : 24'd0;
  assign sum_r = sat_add(rd_first ? 8'd0 : acc_r, term[23:16]);
  assign sum_g = sat_add(rd_first ? 8'd0 : acc_g, term[15:8]);
  assign sum_b = sat_add(rd_first ? 8'd0 : acc_b, term[7:0]);

  always_ff @(posedge clk) begin
    if (adv && rd_vld) begin
      acc_r <= sum_r;
      acc_g <= sum_g;
      acc_b <= sum_b;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && rd_vld && rd_final_layer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rd_vld && rd_final_layer) begin
      out_data.led_out   <= 6'(rd_led);
      out_data.red_out   <= sum_r;
      out_data.green_out <= sum_g;
      out_data.blue_out  <= sum_b;
      out_data.last_led  <= rd_led == LED_W'(LED_COUNT - 1);
    end
  end

endmodule
